FILE: rtl/awlr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// awlr_pkg
// Shared widths, register indexes and the queue word type of the line
// resampler.
// ----------------------------------------------------------------------------
package awlr_pkg;

   // field widths
   localparam int LEN_W     = 13;
   localparam int COLOR_W   = 24;
   localparam int ALPHA_W   = 8;
   localparam int CHAN_W    = 8;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_LEN      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DST_LEN      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA_ENABLE = 2'd2;

   // datapath widths
   localparam int POS_W     = 27;          // i*sn, (2i+1)*sn and area edges
   localparam int W_W       = 17;          // sample weight, up to 65536
   localparam int WA_W      = 25;          // weight times alpha
   localparam int AA_W      = 25;          // alpha weight total
   localparam int ACC_W     = 34;          // channel sums
   localparam int NUM_W     = 42;          // divider numerator
   localparam int DEN_W     = 25;          // divider denominator
   localparam int DIV_CNT_W = 6;           // holds NUM_W

   // 16.16 constants
   localparam logic [15:0]    HALF_ONE = 16'h8000;
   localparam logic [W_W-1:0] ONE_16   = 17'h10000;
   localparam logic [7:0]     FULL_ALPHA = 8'hff;

   // word carried from the front to the back
   typedef struct packed {
      logic               gen;
      logic [LEN_W-1:0]   idx;
      logic               last;
      logic [COLOR_W-1:0] color;
      logic [ALPHA_W-1:0] alpha;
   } qent_type;

endpackage
`default_nettype wire

FILE: rtl/alpha_weighted_line_resampler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alpha_weighted_line_resampler
// Resamples one line of colour plus alpha by area average (shrink) or
// bilinear interpolation (stretch); holds the length and alpha registers.
//
//   port group  direction  handshake            words
//   req_*       in         req_valid/req_ready  load sample or generate pixel
//   rsp_*       out        rsp_valid/rsp_ready  one per generate word
//   csr_*       in         csr_we               length and alpha registers
//
// A load word is written to the line store as it leaves the two-entry queue.
// A generate word runs the position division and then each rounded division
// in the shared bit-serial divider, reads each covered source sample or the
// two bilinear neighbours, and rounds bilinear sums by a shift where no
// division is used; a zero alpha weight skips the colour divisions.
// Reset clears positions to zero and lengths to one; the line store is not
// cleared. While a result waits on rsp_ready the back end still executes
// queued words until its next result is ready, so the queue still drains.
// ----------------------------------------------------------------------------
module alpha_weighted_line_resampler #(
   parameter int MAX_LINE = 4096
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_mode,
   input  wire logic [awlr_pkg::COLOR_W-1:0]     req_pixel_color,
   input  wire logic [awlr_pkg::ALPHA_W-1:0]     req_pixel_alpha,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [awlr_pkg::COLOR_W-1:0]     rsp_out_color,
   output logic      [awlr_pkg::ALPHA_W-1:0]     rsp_out_alpha,
   output logic                                  rsp_last,
   input  wire logic                             csr_we,
   input  wire logic [awlr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [awlr_pkg::LEN_W-1:0]       csr_wdata
);
   import awlr_pkg::*;

   logic [LEN_W-1:0] src_len_ff, src_len_in;
   logic [LEN_W-1:0] dst_len_ff, dst_len_in;
   logic             alpha_en_ff, alpha_en_in;
   logic             cfg_clear;
   logic [LEN_W-1:0] sn, dn;
   logic             q_valid, q_pop;
   qent_type         q_data;

   function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
      logic [LEN_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = LEN_W'(1);
      end else if (32'(v) > MAX_LINE) begin
         r = LEN_W'(MAX_LINE);
      end
      return r;
   endfunction

   // register writes
   always_comb begin
      src_len_in  = src_len_ff;
      dst_len_in  = dst_len_ff;
      alpha_en_in = alpha_en_ff;
      cfg_clear   = 1'b0;
      if (csr_we) begin
         case (csr_index)
            REG_SRC_LEN: begin
               src_len_in = csr_wdata;
               cfg_clear  = 1'b1;
            end
            REG_DST_LEN: begin
               dst_len_in = csr_wdata;
               cfg_clear  = 1'b1;
            end
            REG_ALPHA_ENABLE: begin
               alpha_en_in = csr_wdata[0];
               cfg_clear   = 1'b1;
            end
            default: cfg_clear = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_len_ff  <= LEN_W'(1);
         dst_len_ff  <= LEN_W'(1);
         alpha_en_ff <= 1'b0;
      end else begin
         src_len_ff  <= src_len_in;
         dst_len_ff  <= dst_len_in;
         alpha_en_ff <= alpha_en_in;
      end
   end

   assign sn = eff_len(src_len_ff);
   assign dn = eff_len(dst_len_ff);

   awlr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_pixel_color (req_pixel_color),
      .req_pixel_alpha (req_pixel_alpha),
      .cfg_clear       (cfg_clear),
      .sn              (sn),
      .dn              (dn),
      .q_valid         (q_valid),
      .q_data          (q_data),
      .q_pop           (q_pop)
   );

   awlr_back #(.MAX_LINE(MAX_LINE)) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_data        (q_data),
      .q_pop         (q_pop),
      .sn            (sn),
      .dn            (dn),
      .alpha_en      (alpha_en_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_color (rsp_out_color),
      .rsp_out_alpha (rsp_out_alpha),
      .rsp_last      (rsp_last)
   );

endmodule
`default_nettype wire

FILE: rtl/awlr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// awlr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module awlr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

FILE: rtl/awlr_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// awlr_div
// Restoring divider, one quotient bit per cycle, gives quotient and remainder.
// ----------------------------------------------------------------------------
module awlr_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [awlr_pkg::NUM_W-1:0]   num,
   input  wire logic [awlr_pkg::DEN_W-1:0]   den,
   output logic                              busy,
   output logic                              done,
   output logic      [awlr_pkg::NUM_W-1:0]   quot,
   output logic      [awlr_pkg::DEN_W-1:0]   rem
);
   import awlr_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DEN_W:0]       trial;
   logic                 ge;

   // one trial subtract per cycle
   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      ge      = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(NUM_W);
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], ge};
         rem_in = ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;

endmodule
`default_nettype wire

FILE: rtl/awlr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// awlr_front
// Takes request words, tags them with load address or output index and the
// last flag, and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module awlr_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_mode,
   input  wire logic [awlr_pkg::COLOR_W-1:0]   req_pixel_color,
   input  wire logic [awlr_pkg::ALPHA_W-1:0]   req_pixel_alpha,
   input  wire logic                           cfg_clear,
   input  wire logic [awlr_pkg::LEN_W-1:0]     sn,
   input  wire logic [awlr_pkg::LEN_W-1:0]     dn,
   output logic                                q_valid,
   output awlr_pkg::qent_type                  q_data,
   input  wire logic                           q_pop
);
   import awlr_pkg::*;

   qent_type         slot_ff [2];
   qent_type         entry;
   logic [1:0]       count_ff, count_in;
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [LEN_W-1:0] load_pos_ff, load_pos_in;
   logic [LEN_W-1:0] out_pos_ff, out_pos_in;
   logic [LEN_W-1:0] cur_i;
   logic [LEN_W:0]   load_nxt;
   logic [LEN_W:0]   out_nxt;
   logic             push;

   assign req_ready = count_ff != 2'd2;
   assign push      = req_valid && req_ready;
   assign q_valid   = count_ff != 2'd0;
   assign q_data    = slot_ff[rd_ptr_ff];

   // classify the word and step the positions
   always_comb begin
      cur_i       = (out_pos_ff >= dn) ? '0 : out_pos_ff;
      load_nxt    = {1'b0, load_pos_ff} + 1'b1;
      out_nxt     = {1'b0, cur_i} + 1'b1;
      entry.gen   = req_mode;
      entry.idx   = req_mode ? cur_i : load_pos_ff;
      entry.last  = req_mode && (out_nxt == {1'b0, dn});
      entry.color = req_pixel_color;
      entry.alpha = req_pixel_alpha;
      load_pos_in = load_pos_ff;
      out_pos_in  = out_pos_ff;
      if (cfg_clear) begin
         load_pos_in = '0;
         out_pos_in  = '0;
      end else if (push) begin
         if (req_mode) begin
            out_pos_in = (out_nxt >= {1'b0, dn}) ? '0 : out_nxt[LEN_W-1:0];
         end else begin
            load_pos_in = (load_nxt >= {1'b0, sn}) ? '0 : load_nxt[LEN_W-1:0];
         end
      end
   end

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      case ({push, q_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         wr_ptr_ff   <= 1'b0;
         rd_ptr_ff   <= 1'b0;
         load_pos_ff <= '0;
         out_pos_ff  <= '0;
      end else begin
         count_ff    <= count_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         load_pos_ff <= load_pos_in;
         out_pos_ff  <= out_pos_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/awlr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// awlr_back
// Executes queued words: loads write the line store, generates walk the
// covered samples (area average) or the two neighbours (bilinear), then round
// each channel by a division or a shift and fill the result register.
// ----------------------------------------------------------------------------
module awlr_back #(
   parameter int MAX_LINE = 4096
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           q_valid,
   input  awlr_pkg::qent_type                  q_data,
   output logic                                q_pop,
   input  wire logic [awlr_pkg::LEN_W-1:0]     sn,
   input  wire logic [awlr_pkg::LEN_W-1:0]     dn,
   input  wire logic                           alpha_en,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [awlr_pkg::COLOR_W-1:0]   rsp_out_color,
   output logic      [awlr_pkg::ALPHA_W-1:0]   rsp_out_alpha,
   output logic                                rsp_last
);
   import awlr_pkg::*;

   localparam int AW   = $clog2(MAX_LINE);
   localparam int PP_W = LEN_W + 16;
   localparam int MW   = COLOR_W + ALPHA_W;

   typedef enum logic [3:0] {
      S_IDLE, S_PREP, S_POS, S_LOOP, S_RD, S_MUL, S_ACC, S_DIV, S_DWAIT, S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic               last_ff, last_in;
   logic               area_ff, area_in;
   logic [POS_W-1:0]   lo_ff, lo_in;
   logic [POS_W-1:0]   hi_ff, hi_in;
   logic [POS_W-1:0]   s_ff, s_in;
   logic [LEN_W-1:0]   j_ff, j_in;
   logic [LEN_W-1:0]   j1_ff, j1_in;
   logic [15:0]        f_ff, f_in;
   logic               second_ff, second_in;
   logic [W_W-1:0]     w_ff, w_in;
   logic [WA_W-1:0]    wa_ff, wa_in;
   logic [COLOR_W-1:0] pix_ff, pix_in;
   logic [ACC_W-1:0]   acc_ff [3];
   logic [ACC_W-1:0]   acc_in [3];
   logic [AA_W-1:0]    acc_a_ff, acc_a_in;
   logic [1:0]         k_ff, k_in;
   logic [CHAN_W-1:0]  res_ff [4];
   logic [CHAN_W-1:0]  res_in [4];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0] rsp_color_ff, rsp_color_in;
   logic [ALPHA_W-1:0] rsp_alpha_ff, rsp_alpha_in;
   logic               rsp_last_ff, rsp_last_in;

   // store and divider hookup
   logic               ram_we, ram_re;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [MW-1:0]      ram_wdata, ram_rdata;
   logic [LEN_W-1:0]   rd_j;
   logic               div_start, div_busy, div_done;
   logic [NUM_W-1:0]   div_num, div_quot;
   logic [DEN_W-1:0]   div_den, div_rem;

   // scratch
   logic [LEN_W:0]     fac;
   logic [NUM_W-1:0]   pos;
   logic [PP_W-1:0]    maxp, posc;
   logic [LEN_W:0]     j0p;
   logic [POS_W-1:0]   e_pos, top, bot;
   logic               go;
   logic [CHAN_W-1:0]  amul;
   logic [W_W-1:0]     unit;
   logic [DEN_W-1:0]   cden;
   logic               skip_col;
   logic [ACC_W-1:0]   acc_sel;
   logic               shift_div;
   logic [ACC_W-1:0]   rnd_sum;

   awlr_ram #(.WIDTH(MW), .DEPTH(MAX_LINE)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   awlr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   assign ram_waddr = AW'(q_data.idx);
   assign ram_wdata = {q_data.alpha, q_data.color};
   assign ram_raddr = AW'(rd_j);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      last_in      = last_ff;
      area_in      = area_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      s_in         = s_ff;
      j_in         = j_ff;
      j1_in        = j1_ff;
      f_in         = f_ff;
      second_in    = second_ff;
      w_in         = w_ff;
      wa_in        = wa_ff;
      pix_in       = pix_ff;
      acc_in       = acc_ff;
      acc_a_in     = acc_a_ff;
      k_in         = k_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_color_in = rsp_color_ff;
      rsp_alpha_in = rsp_alpha_ff;
      rsp_last_in  = rsp_last_ff;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      rd_j         = j_ff;
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = '0;

      fac      = q_data.gen && (dn <= sn) ? {1'b0, q_data.idx} : {q_data.idx, 1'b1};
      pos      = (div_quot < NUM_W'(HALF_ONE)) ? '0 : div_quot - NUM_W'(HALF_ONE);
      maxp     = {sn - 1'b1, 16'h0000};
      posc     = (pos > NUM_W'(maxp)) ? maxp : pos[PP_W-1:0];
      j0p      = {1'b0, posc[PP_W-1:16]} + 1'b1;
      e_pos    = s_ff + POS_W'(dn);
      top      = (e_pos < hi_ff) ? e_pos : hi_ff;
      bot      = (s_ff > lo_ff) ? s_ff : lo_ff;
      go       = (j_ff < sn) && (s_ff < hi_ff);
      amul     = alpha_en ? ram_rdata[MW-1:COLOR_W] : 8'd1;
      unit     = area_ff ? W_W'(sn) : ONE_16;
      cden     = alpha_en ? DEN_W'(acc_a_ff) : DEN_W'(unit);
      skip_col = alpha_en && (acc_a_ff == '0);
      case (k_ff)
         2'd0:    acc_sel = acc_ff[0];
         2'd1:    acc_sel = acc_ff[1];
         2'd2:    acc_sel = acc_ff[2];
         default: acc_sel = ACC_W'(acc_a_ff);
      endcase
      // bilinear alpha sums, and all bilinear sums without alpha, round by a shift
      shift_div = !area_ff && ((k_ff == 2'd3) || !alpha_en);
      rnd_sum   = acc_sel + ACC_W'(HALF_ONE);

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (!q_data.gen) begin
                  ram_we = 1'b1;
               end else begin
                  last_in  = q_data.last;
                  area_in  = dn <= sn;
                  lo_in    = POS_W'(fac) * POS_W'(sn);
                  acc_in   = '{default: '0};
                  acc_a_in = '0;
                  state_in = S_PREP;
               end
            end
         end
         // position division: i*sn/dn or (2i+1)*sn*32768/dn
         S_PREP: begin
            div_start = 1'b1;
            div_num   = area_ff ? NUM_W'(lo_ff) : {lo_ff, 15'h0000};
            div_den   = DEN_W'(dn);
            hi_in     = lo_ff + POS_W'(sn);
            state_in  = S_POS;
         end
         S_POS: begin
            if (div_done) begin
               if (area_ff) begin
                  j_in     = LEN_W'(div_quot);
                  s_in     = lo_ff - POS_W'(div_rem);
                  state_in = S_LOOP;
               end else begin
                  j_in      = posc[PP_W-1:16];
                  f_in      = posc[15:0];
                  w_in      = ONE_16 - W_W'(posc[15:0]);
                  j1_in     = (j0p < {1'b0, sn}) ? j0p[LEN_W-1:0] : posc[PP_W-1:16];
                  second_in = 1'b1;
                  state_in  = S_RD;
               end
            end
         end
         // area walk over the covered source samples
         S_LOOP: begin
            if (go) begin
               ram_re   = 1'b1;
               w_in     = W_W'(top - bot);
               j_in     = j_ff + 1'b1;
               s_in     = e_pos;
               state_in = S_MUL;
            end else begin
               k_in     = 2'd0;
               state_in = S_DIV;
            end
         end
         S_RD: begin
            ram_re   = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            wa_in    = WA_W'(w_ff) * WA_W'(amul);
            pix_in   = ram_rdata[COLOR_W-1:0];
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in[0] = acc_ff[0] + ACC_W'(wa_ff) * ACC_W'(pix_ff[23:16]);
            acc_in[1] = acc_ff[1] + ACC_W'(wa_ff) * ACC_W'(pix_ff[15:8]);
            acc_in[2] = acc_ff[2] + ACC_W'(wa_ff) * ACC_W'(pix_ff[7:0]);
            acc_a_in  = acc_a_ff + AA_W'(wa_ff);
            if (area_ff) begin
               state_in = S_LOOP;
            end else if (second_ff) begin
               j_in      = j1_ff;
               w_in      = {1'b0, f_ff};
               second_in = 1'b0;
               state_in  = S_RD;
            end else begin
               k_in     = 2'd0;
               state_in = S_DIV;
            end
         end
         // rounded divisions or shifts: red, green, blue, then alpha when enabled
         S_DIV: begin
            if (shift_div) begin
               res_in[k_ff] = rnd_sum[16+CHAN_W-1:16];
               if (k_ff == 2'd3) begin
                  state_in = S_DONE;
               end else if (k_ff == 2'd2 && !alpha_en) begin
                  res_in[3] = FULL_ALPHA;
                  state_in  = S_DONE;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end else if (k_ff == 2'd3) begin
               div_start = 1'b1;
               div_num   = NUM_W'(acc_a_ff) + NUM_W'(unit >> 1);
               div_den   = DEN_W'(unit);
               state_in  = S_DWAIT;
            end else if (skip_col) begin
               res_in[k_ff] = '0;
               k_in         = k_ff + 2'd1;
            end else begin
               div_start = 1'b1;
               div_num   = NUM_W'(acc_sel) + NUM_W'(cden >> 1);
               div_den   = cden;
               state_in  = S_DWAIT;
            end
         end
         S_DWAIT: begin
            if (div_done) begin
               res_in[k_ff] = div_quot[CHAN_W-1:0];
               if (k_ff == 2'd3) begin
                  state_in = S_DONE;
               end else if (k_ff == 2'd2 && !alpha_en) begin
                  res_in[3] = FULL_ALPHA;
                  state_in  = S_DONE;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = S_DIV;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_color_in = {res_ff[0], res_ff[1], res_ff[2]};
               rsp_alpha_in = res_ff[3];
               rsp_last_in  = last_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff      <= last_in;
      area_ff      <= area_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      s_ff         <= s_in;
      j_ff         <= j_in;
      j1_ff        <= j1_in;
      f_ff         <= f_in;
      second_ff    <= second_in;
      w_ff         <= w_in;
      wa_ff        <= wa_in;
      pix_ff       <= pix_in;
      acc_ff       <= acc_in;
      acc_a_ff     <= acc_a_in;
      k_ff         <= k_in;
      res_ff       <= res_in;
      rsp_color_ff <= rsp_color_in;
      rsp_alpha_ff <= rsp_alpha_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_color = rsp_color_ff;
   assign rsp_out_alpha = rsp_alpha_ff;
   assign rsp_last      = rsp_last_ff;

   // queue word taken only when one is there
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   // divider never restarted mid-division
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   // store reads stay inside the loaded line
   a_rd_range: assert property (@(posedge clock) disable iff (reset)
      ram_re |-> (rd_j < sn))
      else $error("line store read beyond source length");

endmodule
`default_nettype wire

FILE: tb/tb_alpha_weighted_line_resampler.sv
// ----------------------------------------------------------------------------
// tb_alpha_weighted_line_resampler
// Self-checking bench for the line resampler. A short table of load,
// generate and register rows comes first, then a maximum-length check and
// random phases. Each phase sets the lengths and alpha mode, loads a whole
// line and then mixes generate and load words. Each generate word is checked
// against a table value or a local area-average / bilinear model, in order.
// ----------------------------------------------------------------------------
module tb_alpha_weighted_line_resampler;
   import awlr_pkg::*;

   localparam int LINE_MAX   = 4096;
   localparam int STALL_LIM  = 100000;
   localparam int SETTLE_CYC = 60;
   localparam int RAND_WORDS = 1380;

   typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_GEN} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   idx;
      logic [COLOR_W-1:0]     data;
      logic [ALPHA_W-1:0]     alpha;
      logic                   chk;
      logic [COLOR_W-1:0]     exp_color;
      logic [ALPHA_W-1:0]     exp_alpha;
      logic                   exp_last;
   } row_type;

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic [ALPHA_W-1:0] alpha;
      logic               last;
   } pixel_type;

   localparam int N_ROWS = 26;
   localparam row_type DIRECTED [N_ROWS] = '{
      '{ROW_LOAD, REG_SRC_LEN, 24'hffffff, 8'h00, 1'b0, 24'h0, 8'h0, 1'b0},
      '{ROW_GEN,  REG_SRC_LEN, 24'h0, 8'h0, 1'b1, 24'hffffff, 8'hff, 1'b1},
      '{ROW_LOAD, REG_SRC_LEN, 24'h000000, 8'hff, 1'b0, 24'h0, 8'h0, 1'b0},
      '{ROW_GEN,  REG_SRC_LEN, 24'h0, 8'h0, 1'b1, 24'h000000, 8'hff, 1'b1},
      '{ROW_CFG,  REG_ALPHA_ENABLE, 24'd1, 8'h0, 1'b0, 24'h0, 8'h0, 1'b0},
      '{ROW_LOAD, REG_SRC_LEN, 24'h123456, 8'h00, 1'b0, 24'h0, 8'h0, 1'b0},
      // zero total alpha weight gives black and zero alpha
      '{ROW_GEN,  REG_SRC_LEN, 24'h0, 8'h0, 1'b1, 24'h000000, 8'h00, 1'b1},
      '{ROW_LOAD, REG_SRC_LEN, 24'habcdef, 8'hff, 1'b0, 24'h0, 8'h0, 1'b0},
      '{ROW_GEN,  REG_SRC_LEN, 24'h0, 8'h0, 1'b1, 24'habcdef, 8'hff, 1'b1},
      // zero length acts as one, oversized length acts as the maximum
      '{ROW_CFG,  REG_SRC_LEN, 24'd0, 8'h0, 1'b0, 24'h0, 8'h0, 1'b0},
      '{ROW_CFG,  REG_DST_LEN, 24'd8191, 8'h0, 1'b0, 24'h0, 8'h0, 1'b0},
      '{ROW_GEN,  REG_SRC_LEN, 24'h0, 8'h0, 1'b1, 24'habcdef, 8'hff, 1'b0},
      '{ROW_GEN,  REG_SRC_LEN, 24'h0, 8'h0, 1'b1, 24'habcdef, 8'hff, 1'b0},
      '{ROW_CFG,  REG_SRC_LEN, 24'd2, 8'h0, 1'b0, 24'h0, 8'h0, 1'b0},
      '{ROW_CFG,  REG_DST_LEN, 24'd3, 8'h0, 1'b0, 24'h0, 8'h0, 1'b0},
      '{ROW_CFG,  REG_ALPHA_ENABLE, 24'd0, 8'h0, 1'b0, 24'h0, 8'h0, 1'b0},
      '{ROW_LOAD, REG_SRC_LEN, 24'hff0000, 8'h80, 1'b0, 24'h0, 8'h0, 1'b0},
      '{ROW_LOAD, REG_SRC_LEN, 24'h0000ff, 8'h01, 1'b0, 24'h0, 8'h0, 1'b0},
      '{ROW_GEN,  REG_SRC_LEN, 24'h0, 8'h0, 1'b0, 24'h0, 8'h0, 1'b0},
      '{ROW_GEN,  REG_SRC_LEN, 24'h0, 8'h0, 1'b0, 24'h0, 8'h0, 1'b0},
      '{ROW_GEN,  REG_SRC_LEN, 24'h0, 8'h0, 1'b0, 24'h0, 8'h0, 1'b0},
      '{ROW_CFG,  REG_ALPHA_ENABLE, 24'd1, 8'h0, 1'b0, 24'h0, 8'h0, 1'b0},
      '{ROW_GEN,  REG_SRC_LEN, 24'h0, 8'h0, 1'b0, 24'h0, 8'h0, 1'b0},
      '{ROW_GEN,  REG_SRC_LEN, 24'h0, 8'h0, 1'b0, 24'h0, 8'h0, 1'b0},
      '{ROW_CFG,  REG_DST_LEN, 24'd1, 8'h0, 1'b0, 24'h0, 8'h0, 1'b0},
      '{ROW_GEN,  REG_SRC_LEN, 24'h0, 8'h0, 1'b0, 24'h0, 8'h0, 1'b0}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_mode = 1'b0;
   logic [COLOR_W-1:0]   req_pixel_color = '0;
   logic [ALPHA_W-1:0]   req_pixel_alpha = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [COLOR_W-1:0]   rsp_out_color;
   logic [ALPHA_W-1:0]   rsp_out_alpha;
   logic                 rsp_last;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [LEN_W-1:0]     csr_wdata = '0;

   // local copy of the line, positions and registers
   logic [COLOR_W-1:0] line_color [LINE_MAX];
   logic [ALPHA_W-1:0] line_alpha [LINE_MAX];
   int unsigned        load_pos, out_pos;
   logic [LEN_W-1:0]   src_reg, dst_reg;
   logic               alpha_on;

   pixel_type pending_pixels [$];
   bit     failed = 1'b0;
   bit     no_idle = 1'b0;
   bit     long_hold = 1'b0;
   int     idle_cycles = 0;
   int     rand_words = 0;

   alpha_weighted_line_resampler #(.MAX_LINE(LINE_MAX)) u_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint unsigned eff_len(logic [LEN_W-1:0] v);
      if (v == 0) return 1;
      if (v > LINE_MAX) return LINE_MAX;
      return v;
   endfunction

   function automatic longint unsigned rdiv(longint unsigned n, longint unsigned d);
      return (n + d / 2) / d;
   endfunction

   function automatic longint unsigned chan(logic [COLOR_W-1:0] c, int k);
      return (c >> (8 * k)) & 8'hff;
   endfunction

   function automatic logic [COLOR_W-1:0] pack_rgb(longint unsigned r, longint unsigned g,
                                                   longint unsigned b);
      return {r[7:0], g[7:0], b[7:0]};
   endfunction

   // area average of the source span covered by output pixel i
   function automatic pixel_type shrink_pixel(longint unsigned i, longint unsigned sn,
                                              longint unsigned dn);
      longint unsigned lo, hi, j0, j1, s, e, top, bot, w, a;
      longint unsigned acc [3];
      longint unsigned aa;
      pixel_type px;
      lo = i * sn;
      hi = lo + sn;
      j0 = lo / dn;
      j1 = (hi + dn - 1) / dn;
      aa = 0;
      acc = '{0, 0, 0};
      if (j1 > sn) j1 = sn;
      for (longint unsigned j = j0; j < j1; j++) begin
         s = j * dn;
         e = s + dn;
         top = (e < hi) ? e : hi;
         bot = (s > lo) ? s : lo;
         if (top > bot) begin
            w = top - bot;
            if (alpha_on) begin
               a = line_alpha[j];
               aa += w * a;
               w *= a;
            end
            for (int k = 0; k < 3; k++) acc[k] += w * chan(line_color[j], k);
         end
      end
      if (alpha_on) begin
         px.alpha = ALPHA_W'(rdiv(aa, sn));
         px.color = (aa == 0) ? '0 : pack_rgb(rdiv(acc[2], aa), rdiv(acc[1], aa),
                                              rdiv(acc[0], aa));
      end else begin
         px.alpha = FULL_ALPHA;
         px.color = pack_rgb(rdiv(acc[2], sn), rdiv(acc[1], sn), rdiv(acc[0], sn));
      end
      px.last = 1'b0;
      return px;
   endfunction

   // bilinear tap between two neighbors, centre in 16.16
   function automatic pixel_type stretch_pixel(longint unsigned i, longint unsigned sn,
                                               longint unsigned dn);
      longint unsigned num, pos, maxp, j0, j1, f, nf, w0, w1, tot;
      longint unsigned ch [3];
      pixel_type px;
      num = ((2 * i + 1) * sn * 32768) / dn;
      pos = (num < 32768) ? 0 : num - 32768;
      maxp = (sn - 1) << 16;
      if (pos > maxp) pos = maxp;
      j0 = pos >> 16;
      f = pos & 16'hffff;
      nf = 65536 - f;
      j1 = (j0 + 1 < sn) ? j0 + 1 : j0;
      if (alpha_on) begin
         w0 = line_alpha[j0] * nf;
         w1 = line_alpha[j1] * f;
         tot = w0 + w1;
         px.alpha = ALPHA_W'((tot + 32768) >> 16);
         for (int k = 0; k < 3; k++)
            ch[k] = (tot == 0) ? 0 : rdiv(w0 * chan(line_color[j0], k)
                                          + w1 * chan(line_color[j1], k), tot);
      end else begin
         px.alpha = FULL_ALPHA;
         for (int k = 0; k < 3; k++)
            ch[k] = (chan(line_color[j0], k) * nf + chan(line_color[j1], k) * f
                     + 32768) >> 16;
      end
      px.color = pack_rgb(ch[2], ch[1], ch[0]);
      px.last = 1'b0;
      return px;
   endfunction

   // apply one accepted word to the local state; returns a pixel for generates
   function automatic bit apply_word(logic mode, logic [COLOR_W-1:0] c,
                                     logic [ALPHA_W-1:0] a, output pixel_type px);
      longint unsigned sn, dn, i;
      sn = eff_len(src_reg);
      dn = eff_len(dst_reg);
      px = '0;
      if (!mode) begin
         line_color[load_pos] = c;
         line_alpha[load_pos] = a;
         load_pos = (load_pos + 1 >= sn) ? 0 : load_pos + 1;
         return 1'b0;
      end
      i = out_pos;
      if (i >= dn) i = 0;
      px = (dn <= sn) ? shrink_pixel(i, sn, dn) : stretch_pixel(i, sn, dn);
      px.last = (i + 1 == dn);
      out_pos = (i + 1 >= dn) ? 0 : i + 1;
      return 1'b1;
   endfunction

   // offer one word and wait for it to be taken
   task automatic send_word(logic mode, logic [COLOR_W-1:0] c, logic [ALPHA_W-1:0] a,
                            bit chk, pixel_type typed);
      int gap;
      pixel_type px;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_pixel_color <= c;
      req_pixel_alpha <= a;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (apply_word(mode, c, a, px))
         pending_pixels.push_back(chk ? typed : px);
   endtask

   // drop valid, let every result drain and the last load retire
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_SRC_LEN:      src_reg = val;
         REG_DST_LEN:      dst_reg = val;
         REG_ALPHA_ENABLE: alpha_on = val[0];
         default: ;
      endcase
      load_pos = 0;
      out_pos = 0;
   endtask

   task automatic load_line(bit dark);
      for (longint unsigned n = 0; n < eff_len(src_reg); n++)
         send_word(1'b0, COLOR_W'($urandom),
                   dark ? 8'h00 : ALPHA_W'($urandom_range(0, 255)), 1'b0, '0);
   endtask

   // result side: random stalls, one long hold on request, ordered compare
   initial begin : rsp_side
      int stall;
      pixel_type want;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_ready <= 1'b0;
            repeat (2000) @(posedge clock);
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (pending_pixels.size() == 0) begin
            $error("unexpected result word color=%h alpha=%h last=%b",
                   rsp_out_color, rsp_out_alpha, rsp_last);
            failed = 1'b1;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_out_color !== want.color) begin
               $error("out_color expected %h got %h", want.color, rsp_out_color);
               failed = 1'b1;
            end
            if (rsp_out_alpha !== want.alpha) begin
               $error("out_alpha expected %h got %h", want.alpha, rsp_out_alpha);
               failed = 1'b1;
            end
            if (rsp_last !== want.last) begin
               $error("last expected %b got %b", want.last, rsp_last);
               failed = 1'b1;
            end
         end
      end
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIM) begin
         $display("tb_alpha_weighted_line_resampler NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      row_type   r;
      pixel_type typed;
      int        words;
      src_reg = 1;
      dst_reg = 1;
      alpha_on = 1'b0;
      load_pos = 0;
      out_pos = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (DIRECTED[n]) begin
         r = DIRECTED[n];
         typed = '{r.exp_color, r.exp_alpha, r.exp_last};
         case (r.kind)
            ROW_CFG:  write_reg(r.idx, r.data[LEN_W-1:0]);
            ROW_LOAD: send_word(1'b0, r.data, r.alpha, 1'b0, '0);
            default:  send_word(1'b1, '0, '0, r.chk, typed);
         endcase
      end

      // maximum lengths, reading only the head of the line
      write_reg(REG_ALPHA_ENABLE, LEN_W'(0));
      write_reg(REG_SRC_LEN, LEN_W'(5000));
      write_reg(REG_DST_LEN, LEN_W'(8191));
      repeat (4) send_word(1'b0, COLOR_W'($urandom), ALPHA_W'($urandom), 1'b0, '0);
      repeat (3) send_word(1'b1, '0, '0, 1'b0, '0);
      write_reg(REG_DST_LEN, LEN_W'(2048));
      write_reg(REG_ALPHA_ENABLE, LEN_W'(1));
      repeat (4) send_word(1'b0, COLOR_W'($urandom), ALPHA_W'($urandom), 1'b0, '0);
      repeat (2) send_word(1'b1, '0, '0, 1'b0, '0);

      // random phases: set registers, load a full line, then mix words
      long_hold = 1'b1;
      while (rand_words < RAND_WORDS) begin
         no_idle = ($urandom_range(0, 3) == 0);
         write_reg(REG_ALPHA_ENABLE, LEN_W'($urandom_range(0, 1)));
         write_reg(REG_SRC_LEN, LEN_W'(($urandom_range(0, 7) == 0) ? $urandom_range(17, 64)
                                                                   : $urandom_range(1, 16)));
         write_reg(REG_DST_LEN, LEN_W'(($urandom_range(0, 7) == 0) ? $urandom_range(25, 80)
                                                                   : $urandom_range(1, 24)));
         load_line($urandom_range(0, 9) == 0);
         rand_words += int'(eff_len(src_reg));
         words = $urandom_range(10, 40);
         repeat (words) begin
            if ($urandom_range(0, 2) == 0)
               send_word(1'b0, COLOR_W'($urandom), ALPHA_W'($urandom_range(0, 255)),
                         1'b0, '0);
            else
               send_word(1'b1, COLOR_W'($urandom), ALPHA_W'($urandom), 1'b0, '0);
         end
         rand_words += words;
      end

      wait_idle();
      repeat (100) @(posedge clock);
      if (!failed) begin
         $display("tb_alpha_weighted_line_resampler OK");
      end else begin
         $display("tb_alpha_weighted_line_resampler NOT OK");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/awlr_pkg.sv
rtl/awlr_ram.sv
rtl/awlr_div.sv
rtl/awlr_front.sv
rtl/awlr_back.sv
rtl/alpha_weighted_line_resampler.sv
tb/tb_alpha_weighted_line_resampler.sv
